FILE: design/kea_pkg.sv
package kea_pkg;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned MsW      = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;

  localparam logic [CodeW-1:0] UpstrokeMask = 8'h80;
  localparam logic [CodeW-1:0] Low7Mask     = 8'h7F;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REPEAT_DELAY = 4'd0,
    REG_REPEAT_RATE  = 4'd1,
    REG_BUTTON_HOLD  = 4'd2,
    REG_MENU_CODE    = 4'd3,
    REG_UP_CODE      = 4'd4,
    REG_DOWN_CODE    = 4'd5,
    REG_PAGE_UP      = 4'd6,
    REG_PAGE_DOWN    = 4'd7
  } kea_reg_e;

  typedef struct packed {
    logic [MsW-1:0]   repeat_delay_ms;
    logic [MsW-1:0]   repeat_rate_ms;
    logic [MsW-1:0]   button_hold_ms;
    logic [CodeW-1:0] menu_code;
    logic [CodeW-1:0] up_code;
    logic [CodeW-1:0] down_code;
    logic [CodeW-1:0] page_up_code;
    logic [CodeW-1:0] page_down_code;
  } kea_cfg_t;

  localparam kea_cfg_t CfgReset = '{
    repeat_delay_ms: 16'd500,
    repeat_rate_ms:  16'd100,
    button_hold_ms:  16'd1000,
    menu_code:       8'd105,
    up_code:         8'd76,
    down_code:       8'd77,
    page_up_code:    8'd72,
    page_down_code:  8'd73
  };

  // Deadline has passed when (deadline - now) is negative as a signed word.
  function automatic logic deadline_passed(input logic [TimeW-1:0] deadline,
                                           input logic [TimeW-1:0] now);
    logic [TimeW-1:0] diff;
    diff = deadline - now;
    return diff[TimeW-1];
  endfunction

  // Codes that map to a letter or digit in the ASCII ROM.
  function automatic logic maps_to_char(input logic [CodeW-1:0] code);
    logic [6:0] k;
    k = 7'(code & Low7Mask);
    if (code[7]) begin
      return 1'b0;
    end
    return (k >= 7'd1  && k <= 7'd10) || (k >= 7'd16 && k <= 7'd25) ||
           (k >= 7'd32 && k <= 7'd40) || (k >= 7'd49 && k <= 7'd55);
  endfunction

endpackage

FILE: design/kea_cfg_regs.sv
module kea_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kea_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kea_pkg::CfgDataW-1:0]  cfg_data_i,
  output kea_pkg::kea_cfg_t             cfg_o
);
  import kea_pkg::*;

  kea_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (kea_reg_e'(cfg_index_i))
        REG_REPEAT_DELAY: cfg_d.repeat_delay_ms = cfg_data_i;
        REG_REPEAT_RATE:  cfg_d.repeat_rate_ms  = cfg_data_i;
        REG_BUTTON_HOLD:  cfg_d.button_hold_ms  = cfg_data_i;
        REG_MENU_CODE:    cfg_d.menu_code       = cfg_data_i[CodeW-1:0];
        REG_UP_CODE:      cfg_d.up_code         = cfg_data_i[CodeW-1:0];
        REG_DOWN_CODE:    cfg_d.down_code       = cfg_data_i[CodeW-1:0];
        REG_PAGE_UP:      cfg_d.page_up_code    = cfg_data_i[CodeW-1:0];
        REG_PAGE_DOWN:    cfg_d.page_down_code  = cfg_data_i[CodeW-1:0];
        default:          cfg_d = cfg_q; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: design/key_event_autorepeat_top.sv
// Key event generator with typematic autorepeat. Each input transfer is one
// poll (key code, menu button level, millisecond time) and yields exactly one
// output transfer carrying the key event, 0 when nothing happened. A poll is
// held in an input register until the output register is free; its event is
// then loaded into the output register and offered. With the event side ready
// the block takes one poll per clock cycle; a stalled event holds the input
// register and stalls the poll side.
// Configuration writes are taken in any cycle and should be issued while no
// poll is in flight.
module key_event_autorepeat_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kea_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kea_pkg::CfgDataW-1:0]  cfg_data_i,
  // Poll stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] key_code, [8] button_pressed, [40:9] now_ms, [47:41] zero
  input  logic [kea_pkg::InDataW-1:0]   s_axis_tdata,
  // Event stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] key_event
  output logic [kea_pkg::OutDataW-1:0]  m_axis_tdata
);
  import kea_pkg::*;

  kea_cfg_t cfg;

  kea_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register
  logic             in_valid_q;
  logic [CodeW-1:0] in_code_q;
  logic             in_pressed_q;
  logic [TimeW-1:0] in_now_q;

  // Output register
  logic             out_valid_q;
  logic [CodeW-1:0] out_event_q, out_event_d;

  // Poll state
  logic [CodeW-1:0] prev_code_q, prev_code_d;
  logic [TimeW-1:0] btn_deadline_q, btn_deadline_d;
  logic             btn_armed_q, btn_armed_d;
  logic [TimeW-1:0] rep_deadline_q, rep_deadline_d;
  logic             rep_phase_q, rep_phase_d;

  logic proc;
  logic in_take;
  logic [CodeW-1:0] code;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_event_q;

  always_comb begin
    code           = in_code_q;
    prev_code_d    = prev_code_q;
    btn_deadline_d = btn_deadline_q;
    btn_armed_d    = btn_armed_q;
    rep_deadline_d = rep_deadline_q;
    rep_phase_d    = rep_phase_q;
    out_event_d    = '0;

    if (!in_pressed_q) begin
      btn_deadline_d = in_now_q + TimeW'(cfg.button_hold_ms);
      btn_armed_d    = 1'b1;
    end else if (btn_armed_q && deadline_passed(btn_deadline_q, in_now_q)) begin
      code        = cfg.menu_code;
      btn_armed_d = 1'b0;
    end

    if (code != prev_code_q) begin
      out_event_d = code;
    end
    prev_code_d = code;

    if ((code & UpstrokeMask) != '0) begin
      rep_deadline_d = in_now_q + TimeW'(cfg.repeat_delay_ms);
    end else if (deadline_passed(rep_deadline_q, in_now_q)) begin
      rep_deadline_d = in_now_q + TimeW'(cfg.repeat_rate_ms);
      if (code == cfg.up_code || code == cfg.down_code) begin
        out_event_d = code;
      end
      // Slow keys repeat on every second firing.
      rep_phase_d = !rep_phase_q;
      if (rep_phase_q && (code == cfg.page_up_code || code == cfg.page_down_code ||
                          maps_to_char(code))) begin
        out_event_d = code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      prev_code_q    <= '0;
      btn_deadline_q <= '0;
      btn_armed_q    <= 1'b1;
      rep_deadline_q <= '0;
      rep_phase_q    <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q    <= 1'b1;
        prev_code_q    <= prev_code_d;
        btn_deadline_q <= btn_deadline_d;
        btn_armed_q    <= btn_armed_d;
        rep_deadline_q <= rep_deadline_d;
        rep_phase_q    <= rep_phase_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_code_q    <= s_axis_tdata[CodeW-1:0];
      in_pressed_q <= s_axis_tdata[CodeW];
      in_now_q     <= s_axis_tdata[CodeW+TimeW:CodeW+1];
    end
    if (proc) begin
      out_event_q <= out_event_d;
    end
  end

  // The button hold disarms only on a poll taken with the button held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(btn_armed_q) |-> $past(proc && in_pressed_q))
    else $error("button disarmed without a held-button poll");

  // A poll with the button released always rearms.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !in_pressed_q) |=> btn_armed_q)
    else $error("button not rearmed after release");

  // An event appears only after a poll was processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc))
    else $error("event without a processed poll");

  // Poll input never stalls while the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // The repeat phase changes only when a poll is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_phase_q != $past(rep_phase_q)) |-> $past(proc))
    else $error("repeat phase changed without a poll");

endmodule
